### design/cau_pkg.sv
// Shared opcode, status and control types of the complex arithmetic unit.
package cau_pkg;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_SAT = 2'd1,
		ST_DZ  = 2'd2
	} status_t;

	typedef struct packed {
		logic div;
		logic dz;
		logic neg_re;
		logic neg_im;
	} ctl_t;

endpackage

### design/cau_front.sv
// Operand register, product stage and combine stage that load the divider cell row.
module cau_front #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_vld,
	output logic                      in_rdy,
	input  cau_pkg::op_t              op,
	input  logic signed [W-1:0]       a_re,
	input  logic signed [W-1:0]       a_im,
	input  logic signed [W-1:0]       b_re,
	input  logic signed [W-1:0]       b_im,
	output logic                      out_vld,
	input  logic                      out_rdy,
	output cau_pkg::ctl_t             out_ctl,
	output logic [2*W+F-1:0]          out_num_re,
	output logic [2*W+F-1:0]          out_num_im,
	output logic [2*W-1:0]            out_den,
	output logic [2*W+F-1:0]          out_q_re,
	output logic [2*W+F-1:0]          out_q_im
);
	import cau_pkg::*;

	localparam int DW = 2 * W;
	localparam int NW = 2 * W + F;

	logic vld_s1, vld_s2, vld_s3;
	logic rdy_s1, rdy_s2, rdy_s3;
	op_t  op_s1, op_s2;
	logic signed [W-1:0] ar_s1, ai_s1, br_s1, bi_s1;
	logic signed [W-1:0] ar_s2, ai_s2, br_s2, bi_s2;
	logic signed [DW-1:0] p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2, sq_r_s2, sq_i_s2;

	logic signed [DW:0] v_re, v_im, t_re, t_im;
	logic [DW:0] m_re, m_im;
	logic [DW-1:0] den;
	ctl_t ctl;
	logic [NW-1:0] num_re, num_im, q_re, q_im;

	ctl_t ctl_s3;
	logic [NW-1:0] num_re_s3, num_im_s3, q_re_s3, q_im_s3;
	logic [DW-1:0] den_s3;

	assign rdy_s3 = !vld_s3 || out_rdy;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;
	assign in_rdy = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_vld;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_vld) begin
			op_s1 <= op;
			ar_s1 <= a_re;
			ai_s1 <= a_im;
			br_s1 <= b_re;
			bi_s1 <= b_im;
		end
		if (rdy_s2 && vld_s1) begin
			op_s2   <= op_s1;
			ar_s2   <= ar_s1;
			ai_s2   <= ai_s1;
			br_s2   <= br_s1;
			bi_s2   <= bi_s1;
			p_rr_s2 <= DW'(ar_s1) * DW'(br_s1);
			p_ii_s2 <= DW'(ai_s1) * DW'(bi_s1);
			p_ri_s2 <= DW'(ar_s1) * DW'(bi_s1);
			p_ir_s2 <= DW'(ai_s1) * DW'(br_s1);
			sq_r_s2 <= DW'(br_s1) * DW'(br_s1);
			sq_i_s2 <= DW'(bi_s1) * DW'(bi_s1);
		end
		if (rdy_s3 && vld_s2) begin
			ctl_s3    <= ctl;
			num_re_s3 <= num_re;
			num_im_s3 <= num_im;
			q_re_s3   <= q_re;
			q_im_s3   <= q_im;
			den_s3    <= den;
		end
	end

	always_comb begin
		t_re = '0;
		t_im = '0;
		v_re = '0;
		v_im = '0;
		case (op_s2)
			OP_ADD: begin
				v_re = (DW+1)'(ar_s2) + (DW+1)'(br_s2);
				v_im = (DW+1)'(ai_s2) + (DW+1)'(bi_s2);
			end
			OP_SUB: begin
				v_re = (DW+1)'(ar_s2) - (DW+1)'(br_s2);
				v_im = (DW+1)'(ai_s2) - (DW+1)'(bi_s2);
			end
			OP_MUL: begin
				t_re = (DW+1)'(p_rr_s2) - (DW+1)'(p_ii_s2);
				t_im = (DW+1)'(p_ri_s2) + (DW+1)'(p_ir_s2);
				v_re = t_re >>> F;
				v_im = t_im >>> F;
			end
			OP_DIV: begin
				v_re = (DW+1)'(p_rr_s2) + (DW+1)'(p_ii_s2);
				v_im = (DW+1)'(p_ir_s2) - (DW+1)'(p_ri_s2);
			end
			default: begin
				v_re = '0;
				v_im = '0;
			end
		endcase
		m_re = v_re[DW] ? -v_re : v_re;
		m_im = v_im[DW] ? -v_im : v_im;
		den = sq_r_s2 + sq_i_s2;
		ctl.div    = (op_s2 == OP_DIV);
		ctl.dz     = (op_s2 == OP_DIV) && (den == '0);
		ctl.neg_re = v_re[DW];
		ctl.neg_im = v_im[DW];
		if (op_s2 == OP_DIV) begin
			num_re = {m_re[DW-1:0], {F{1'b0}}};
			num_im = {m_im[DW-1:0], {F{1'b0}}};
			q_re   = '0;
			q_im   = '0;
		end else begin
			num_re = '0;
			num_im = '0;
			q_re   = NW'(m_re);
			q_im   = NW'(m_im);
		end
	end

	assign out_vld    = vld_s3;
	assign out_ctl    = ctl_s3;
	assign out_num_re = num_re_s3;
	assign out_num_im = num_im_s3;
	assign out_den    = den_s3;
	assign out_q_re   = q_re_s3;
	assign out_q_im   = q_im_s3;

endmodule

### design/cau_cell.sv
// Restoring-division cell; one quotient bit of both parts when dividing.
module cau_cell #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_vld,
	output logic                 in_rdy,
	input  cau_pkg::ctl_t        in_ctl,
	input  logic [2*W+F-1:0]     in_num_re,
	input  logic [2*W+F-1:0]     in_num_im,
	input  logic [2*W-1:0]       in_rem_re,
	input  logic [2*W-1:0]       in_rem_im,
	input  logic [2*W-1:0]       in_den,
	input  logic [2*W+F-1:0]     in_q_re,
	input  logic [2*W+F-1:0]     in_q_im,
	output logic                 out_vld,
	input  logic                 out_rdy,
	output cau_pkg::ctl_t        out_ctl,
	output logic [2*W+F-1:0]     out_num_re,
	output logic [2*W+F-1:0]     out_num_im,
	output logic [2*W-1:0]       out_rem_re,
	output logic [2*W-1:0]       out_rem_im,
	output logic [2*W-1:0]       out_den,
	output logic [2*W+F-1:0]     out_q_re,
	output logic [2*W+F-1:0]     out_q_im
);
	import cau_pkg::*;

	localparam int DW = 2 * W;
	localparam int NW = 2 * W + F;

	logic vld_q;
	ctl_t ctl_q;
	logic [NW-1:0] num_re_q, num_im_q, q_re_q, q_im_q;
	logic [DW-1:0] rem_re_q, rem_im_q, den_q;

	logic [DW:0] trial_re, trial_im, diff_re, diff_im;
	logic take_re, take_im;
	logic [NW-1:0] num_re_nx, num_im_nx, q_re_nx, q_im_nx;
	logic [DW-1:0] rem_re_nx, rem_im_nx;

	assign in_rdy = !vld_q || out_rdy;

	always_comb begin
		trial_re = {in_rem_re, in_num_re[NW-1]};
		trial_im = {in_rem_im, in_num_im[NW-1]};
		diff_re  = trial_re - {1'b0, in_den};
		diff_im  = trial_im - {1'b0, in_den};
		take_re  = trial_re >= {1'b0, in_den};
		take_im  = trial_im >= {1'b0, in_den};
		if (in_ctl.div) begin
			rem_re_nx = take_re ? diff_re[DW-1:0] : trial_re[DW-1:0];
			rem_im_nx = take_im ? diff_im[DW-1:0] : trial_im[DW-1:0];
			num_re_nx = {in_num_re[NW-2:0], 1'b0};
			num_im_nx = {in_num_im[NW-2:0], 1'b0};
			q_re_nx   = {in_q_re[NW-2:0], take_re};
			q_im_nx   = {in_q_im[NW-2:0], take_im};
		end else begin
			rem_re_nx = in_rem_re;
			rem_im_nx = in_rem_im;
			num_re_nx = in_num_re;
			num_im_nx = in_num_im;
			q_re_nx   = in_q_re;
			q_im_nx   = in_q_im;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_rdy) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (in_rdy && in_vld) begin
			ctl_q    <= in_ctl;
			num_re_q <= num_re_nx;
			num_im_q <= num_im_nx;
			rem_re_q <= rem_re_nx;
			rem_im_q <= rem_im_nx;
			den_q    <= in_den;
			q_re_q   <= q_re_nx;
			q_im_q   <= q_im_nx;
		end
	end

	assign out_vld    = vld_q;
	assign out_ctl    = ctl_q;
	assign out_num_re = num_re_q;
	assign out_num_im = num_im_q;
	assign out_rem_re = rem_re_q;
	assign out_rem_im = rem_im_q;
	assign out_den    = den_q;
	assign out_q_re   = q_re_q;
	assign out_q_im   = q_im_q;

endmodule

### design/cau_pack.sv
// Output register that saturates the signed magnitudes and forms the status.
module cau_pack #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_vld,
	output logic                 in_rdy,
	input  cau_pkg::ctl_t        in_ctl,
	input  logic [2*W+F-1:0]     in_q_re,
	input  logic [2*W+F-1:0]     in_q_im,
	output logic                 out_vld,
	input  logic                 out_rdy,
	output logic [W-1:0]         res_re,
	output logic [W-1:0]         res_im,
	output cau_pkg::status_t     status
);
	import cau_pkg::*;

	localparam int NW = 2 * W + F;
	localparam logic [NW-1:0] LIM_P = {{(NW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic [NW-1:0] LIM_N = LIM_P + NW'(1);

	logic vld_q;
	logic [W-1:0] re_q, im_q;
	status_t st_q;

	logic [NW-1:0] lim_re, lim_im;
	logic sat_re, sat_im;
	logic [W-1:0] m_re, m_im, v_re, v_im;
	status_t st;

	assign in_rdy = !vld_q || out_rdy;

	always_comb begin
		lim_re = in_ctl.neg_re ? LIM_N : LIM_P;
		lim_im = in_ctl.neg_im ? LIM_N : LIM_P;
		sat_re = in_q_re > lim_re;
		sat_im = in_q_im > lim_im;
		m_re   = sat_re ? lim_re[W-1:0] : in_q_re[W-1:0];
		m_im   = sat_im ? lim_im[W-1:0] : in_q_im[W-1:0];
		v_re   = in_ctl.neg_re ? -m_re : m_re;
		v_im   = in_ctl.neg_im ? -m_im : m_im;
		st     = (sat_re || sat_im) ? ST_SAT : ST_OK;
		if (in_ctl.dz) begin
			v_re = '0;
			v_im = '0;
			st   = ST_DZ;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_rdy) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (in_rdy && in_vld) begin
			re_q <= v_re;
			im_q <= v_im;
			st_q <= st;
		end
	end

	assign out_vld = vld_q;
	assign res_re  = re_q;
	assign res_im  = im_q;
	assign status  = st_q;

endmodule

### design/complex_arith_unit.sv
// Top level of the complex arithmetic unit: front stages, divider cell row, output stage.
//
// Channel   Dir  Beat contents
// s_*       in   tuser: req_type; tdata: a_re, a_im, b_re, b_im
// m_*       out  tuser: status; tdata: res_re, res_im
//
// Every beat passes 3 front stages, 2*WIDTH+FRAC_BITS divider cells and the
// output register. One beat is accepted per cycle while a stall at m_tready has
// not backed up the pipeline; the row of division cells sets the latency.
// Reset clears only the valid flags. A stall at m_tready reaches the input side
// in the same cycle through the ready chain, and s_tready falls only when every
// stage holds a beat.
module complex_arith_unit #(
	parameter int WIDTH     = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// a_re, a_im, b_re, b_im from the lowest bit up.
	input  logic [((4*WIDTH+7)/8)*8-1:0]        s_tdata,
	// req_type.
	input  cau_pkg::op_t                        s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// res_re, res_im from the lowest bit up.
	output logic [((2*WIDTH+7)/8)*8-1:0]        m_tdata,
	// status.
	output cau_pkg::status_t                    m_tuser
);
	import cau_pkg::*;

	localparam int W   = WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int DW  = 2 * W;
	localparam int NW  = 2 * W + F;
	localparam int ODW = ((2*WIDTH+7)/8)*8;
	localparam logic [W-1:0] RMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] RMIN = {1'b1, {(W-1){1'b0}}};

	logic          vld_w    [0:NW];
	logic          rdy_w    [0:NW];
	ctl_t          ctl_w    [0:NW];
	logic [NW-1:0] num_re_w [0:NW];
	logic [NW-1:0] num_im_w [0:NW];
	logic [DW-1:0] rem_re_w [0:NW];
	logic [DW-1:0] rem_im_w [0:NW];
	logic [DW-1:0] den_w    [0:NW];
	logic [NW-1:0] q_re_w   [0:NW];
	logic [NW-1:0] q_im_w   [0:NW];

	logic [W-1:0] res_re, res_im;

	cau_front #(.W(W), .F(F)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_vld     (s_tvalid),
		.in_rdy     (s_tready),
		.op         (s_tuser),
		.a_re       (s_tdata[W-1:0]),
		.a_im       (s_tdata[2*W-1:W]),
		.b_re       (s_tdata[3*W-1:2*W]),
		.b_im       (s_tdata[4*W-1:3*W]),
		.out_vld    (vld_w[0]),
		.out_rdy    (rdy_w[0]),
		.out_ctl    (ctl_w[0]),
		.out_num_re (num_re_w[0]),
		.out_num_im (num_im_w[0]),
		.out_den    (den_w[0]),
		.out_q_re   (q_re_w[0]),
		.out_q_im   (q_im_w[0])
	);

	assign rem_re_w[0] = '0;
	assign rem_im_w[0] = '0;

	for (genvar i = 0; i < NW; i++) begin : g_cell
		cau_cell #(.W(W), .F(F)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.in_vld     (vld_w[i]),
			.in_rdy     (rdy_w[i]),
			.in_ctl     (ctl_w[i]),
			.in_num_re  (num_re_w[i]),
			.in_num_im  (num_im_w[i]),
			.in_rem_re  (rem_re_w[i]),
			.in_rem_im  (rem_im_w[i]),
			.in_den     (den_w[i]),
			.in_q_re    (q_re_w[i]),
			.in_q_im    (q_im_w[i]),
			.out_vld    (vld_w[i+1]),
			.out_rdy    (rdy_w[i+1]),
			.out_ctl    (ctl_w[i+1]),
			.out_num_re (num_re_w[i+1]),
			.out_num_im (num_im_w[i+1]),
			.out_rem_re (rem_re_w[i+1]),
			.out_rem_im (rem_im_w[i+1]),
			.out_den    (den_w[i+1]),
			.out_q_re   (q_re_w[i+1]),
			.out_q_im   (q_im_w[i+1])
		);
	end

	cau_pack #(.W(W), .F(F)) u_pack (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_w[NW]),
		.in_rdy  (rdy_w[NW]),
		.in_ctl  (ctl_w[NW]),
		.in_q_re (q_re_w[NW]),
		.in_q_im (q_im_w[NW]),
		.out_vld (m_tvalid),
		.out_rdy (m_tready),
		.res_re  (res_re),
		.res_im  (res_im),
		.status  (m_tuser)
	);

	assign m_tdata = ODW'({res_im, res_re});

	// The input side stalls only when the whole pipeline backs up from the output.
	a_stall_origin: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without output back-pressure");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_SAT || m_tuser == ST_DZ))
		else $error("undefined status code");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_DZ) |-> (res_re == '0 && res_im == '0))
		else $error("divide by zero result is not zero");

	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_SAT) |->
		(res_re == RMAX || res_re == RMIN || res_im == RMAX || res_im == RMIN))
		else $error("saturation flagged without a clamped part");

endmodule

### tb/testbench.sv
// Self-checking testbench of the complex arithmetic unit, with a bit-exact predictor and random traffic.
module testbench;
	import cau_pkg::*;

	localparam int WIDTH     = 32;
	localparam int FRAC_BITS = 16;
	localparam int LATENCY   = 2*WIDTH+FRAC_BITS+4;
	localparam int CYCLE_LIMIT = 400000;

	typedef logic signed [WIDTH-1:0] word_t;
	typedef logic signed [127:0] wide_t;

	typedef struct {
		word_t   re;
		word_t   im;
		status_t st;
	} cplx_res_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [4*WIDTH-1:0]   s_tdata;
	op_t                  s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [2*WIDTH-1:0]   m_tdata;
	status_t              m_tuser;

	cplx_res_t pending_results[$];
	int        error_count;
	int        cycle_count;
	int        burst_left;

	complex_arith_unit #(.WIDTH(WIDTH), .FRAC_BITS(FRAC_BITS)) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic word_t clamp_part(wide_t x, inout logic sat);
		wide_t hi_lim;
		wide_t lo_lim;
		hi_lim = (wide_t'(1) <<< (WIDTH-1)) - 1;
		lo_lim = -(wide_t'(1) <<< (WIDTH-1));
		if (x > hi_lim) begin
			sat = 1'b1;
			return hi_lim[WIDTH-1:0];
		end
		if (x < lo_lim) begin
			sat = 1'b1;
			return lo_lim[WIDTH-1:0];
		end
		return x[WIDTH-1:0];
	endfunction

	function automatic cplx_res_t complex_result(op_t op, word_t ar, word_t ai, word_t br,
			word_t bi);
		wide_t xr, xi, yr, yi, re, im, den;
		logic sat;
		cplx_res_t r;
		xr = ar;
		xi = ai;
		yr = br;
		yi = bi;
		sat = 1'b0;
		case (op)
			OP_ADD: begin
				re = xr + yr;
				im = xi + yi;
			end
			OP_SUB: begin
				re = xr - yr;
				im = xi - yi;
			end
			OP_MUL: begin
				re = (xr*yr - xi*yi) >>> FRAC_BITS;
				im = (xr*yi + yr*xi) >>> FRAC_BITS;
			end
			default: begin
				den = yr*yr + yi*yi;
				if (den == 0) begin
					r.re = '0;
					r.im = '0;
					r.st = ST_DZ;
					return r;
				end
				re = ((xr*yr + xi*yi) <<< FRAC_BITS) / den;
				im = ((xi*yr - xr*yi) <<< FRAC_BITS) / den;
			end
		endcase
		r.re = clamp_part(re, sat);
		r.im = clamp_part(im, sat);
		r.st = sat ? ST_SAT : ST_OK;
		return r;
	endfunction

	// Operand values weighted toward magnitudes where multiply and divide stay in range.
	function automatic word_t rand_operand();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: return word_t'(32'h7fffffff);
			1: return word_t'(32'h80000000);
			2: return '0;
			3, 4: return word_t'($urandom());
			5: return word_t'($signed($urandom_range(0, 32'h1ffff)) - 32'sh10000);
			default: return word_t'({{12{$urandom_range(0, 1) == 1}}, 20'($urandom())});
		endcase
	endfunction

	task automatic send_request(op_t op, word_t ar, word_t ai, word_t br, word_t bi);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {bi, br, ai, ar};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_results.push_back(complex_result(op, ar, ai, br, bi));
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(0, 12);
			if ($urandom_range(0, 2) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic test_add_sub_extremes();
		send_request(OP_ADD, 32'sh7fffffff, 32'sh80000000, 32'sh00000001, 32'shffffffff);
		send_request(OP_ADD, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
		send_request(OP_ADD, 32'sh00010000, -32'sh00020000, 32'sh00030000, 32'sh00000000);
		send_request(OP_SUB, 32'sh80000000, 32'sh7fffffff, 32'sh00000001, 32'shffffffff);
		send_request(OP_SUB, 32'sh00000000, 32'sh00000000, 32'sh80000000, 32'sh7fffffff);
		send_request(OP_SUB, 32'sh12345678, -32'sh00001234, 32'sh12345678, -32'sh00001234);
	endtask

	task automatic test_mul_rounding();
		send_request(OP_MUL, 32'sh00010000, 32'sh00000000, 32'sh00020000, 32'sh00030000);
		send_request(OP_MUL, -32'sh00000001, 32'sh00000000, 32'sh00000001, 32'sh00000001);
		send_request(OP_MUL, 32'sh00000001, 32'sh00000001, 32'sh00000001, -32'sh00000001);
		send_request(OP_MUL, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		send_request(OP_MUL, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
		send_request(OP_MUL, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
	endtask

	task automatic test_div_cases();
		send_request(OP_DIV, 32'sh00010000, 32'sh00020000, 32'sh00000000, 32'sh00000000);
		send_request(OP_DIV, 32'sh80000000, 32'sh7fffffff, 32'sh00000000, 32'sh00000000);
		send_request(OP_DIV, 32'sh00030000, 32'sh00010000, 32'sh00010000, 32'sh00000000);
		send_request(OP_DIV, 32'sh00030000, -32'sh00010000, 32'sh00000000, 32'sh00020000);
		send_request(OP_DIV, -32'sh00010000, 32'sh00000001, 32'sh00030000, -32'sh00070000);
		send_request(OP_DIV, 32'sh7fffffff, 32'sh80000000, 32'sh00000001, 32'sh00000000);
		send_request(OP_DIV, 32'sh00000001, -32'sh00000001, 32'sh80000000, 32'sh80000000);
		send_request(OP_DIV, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
	endtask

	task automatic test_random_traffic(int count);
		for (int n = 0; n < count; n++) begin
			send_request(op_t'($urandom_range(0, 3)), rand_operand(), rand_operand(),
				rand_operand(), rand_operand());
			if (n == count/2) wait_drained();
		end
	endtask

	// The receiver switches among always ready, random ready and mostly stalled.
	int unsigned stall_mode;
	int          mode_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_mode <= 0;
			mode_left  <= 0;
		end else begin
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 2);
				mode_left  <= $urandom_range(10, 150);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= $urandom_range(0, 1);
				default: m_tready <= $urandom_range(0, 3) == 0;
			endcase
		end
	end

	always @(posedge clk) begin
		cplx_res_t exp_res;
		word_t got_re;
		word_t got_im;
		if (arst_n && m_tvalid && m_tready) begin
			got_re = m_tdata[WIDTH-1:0];
			got_im = m_tdata[2*WIDTH-1:WIDTH];
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected beat re=%h im=%h status=%s", $time, got_re, got_im,
					m_tuser.name());
				error_count++;
			end else begin
				exp_res = pending_results.pop_front();
				if (got_re !== exp_res.re) begin
					$display("%0t: res_re expected %h actual %h", $time, exp_res.re, got_re);
					error_count++;
				end
				if (got_im !== exp_res.im) begin
					$display("%0t: res_im expected %h actual %h", $time, exp_res.im, got_im);
					error_count++;
				end
				if (m_tuser !== exp_res.st) begin
					$display("%0t: status expected %s actual %s", $time, exp_res.st.name(),
						m_tuser.name());
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		error_count = 0;
		cycle_count = 0;
		burst_left  = 0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= OP_ADD;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_add_sub_extremes();
		test_mul_rounding();
		test_div_cases();
		wait_drained();
		test_random_traffic(1950);
		wait_drained();
		repeat (LATENCY + 20) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
